// ===== src/tspc_pkg.sv =====
// Shared types and constants for the two-axis stepper position controller.
package tspc_pkg;

	localparam int SCALE_SHIFT = 13;

	localparam int LIMIT_W  = 15;
	localparam int SCALE_W  = 15;
	localparam int TARGET_W = 17;
	localparam int POS_W    = 16;
	localparam int METRIC_W = 18;
	localparam int CFG_IDX_W = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32767;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd8192;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRAVEL_LIMIT = 2'd0,
		CFG_METRIC_INPUT = 2'd1,
		CFG_N2M_SCALE    = 2'd2,
		CFG_M2N_SCALE    = 2'd3
	} cfg_index_t;

	// per-axis command for one processed request
	typedef struct packed {
		logic                    load;
		logic                    step;
		logic                    drop;
		logic signed [POS_W-1:0] target;
	} axis_cmd_t;

	// per-axis visible state
	typedef struct packed {
		logic                       step;
		logic                       dir;
		logic                       enable;
		logic signed [POS_W-1:0]    position;
		logic signed [METRIC_W-1:0] metric;
		logic signed [POS_W-1:0]    target;
	} axis_state_t;

endpackage

// ===== src/tspc_axis.sv =====
// One axis: target, position, metric position and step/dir/enable pins.
module tspc_axis (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tspc_pkg::axis_cmd_t           cmd,
	input  logic [tspc_pkg::LIMIT_W-1:0]  travel_limit,
	input  logic [tspc_pkg::SCALE_W-1:0]  scale,
	output tspc_pkg::axis_state_t         state
);
	import tspc_pkg::*;

	logic signed [POS_W-1:0]    pos_q;
	logic signed [POS_W-1:0]    tgt_q;
	logic signed [METRIC_W-1:0] metric_q;
	logic                       enable_q;
	logic                       dir_q;
	logic                       step_q;

	logic                       go_up;
	logic                       idle;
	logic [POS_W:0]             tgt_mag;
	logic signed [POS_W-1:0]    pos_nx;
	logic signed [2*POS_W-1:0]  met_prod;

	assign tgt_mag  = tgt_q[POS_W-1] ? (POS_W+1)'(-{tgt_q[POS_W-1], tgt_q})
	                                 : {1'b0, tgt_q};
	assign idle     = (tgt_q == pos_q) || (tgt_mag > {2'b00, travel_limit});
	assign go_up    = tgt_q > pos_q;
	assign pos_nx   = go_up ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
	// arithmetic shift of the product gives floor for negative positions
	assign met_prod = pos_nx * $signed({1'b0, scale});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tgt_q    <= '0;
			metric_q <= '0;
			enable_q <= 1'b0;
			dir_q    <= 1'b0;
			step_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				tgt_q    <= cmd.target;
				enable_q <= 1'b1;
			end
			if (cmd.step) begin
				if (idle) begin
					enable_q <= 1'b0;
				end else begin
					enable_q <= 1'b1;
					step_q   <= 1'b1;
					dir_q    <= go_up;
					pos_q    <= pos_nx;
					metric_q <= met_prod[SCALE_SHIFT+METRIC_W-1:SCALE_SHIFT];
				end
			end
			if (cmd.drop) begin
				step_q <= 1'b0;
			end
		end
	end

	assign state.step     = step_q;
	assign state.dir      = dir_q;
	assign state.enable   = enable_q;
	assign state.position = pos_q;
	assign state.metric   = metric_q;
	assign state.target   = tgt_q;

endmodule

// ===== src/two_axis_stepper_position_control_unit.sv =====
// Two-axis step/direction position controller, top level.
// A request is registered in the request register, then processed into the result register; a held result can stall it.
// Throughput: one request per cycle; in_ready drops only while a result waits on out_ready.
// Axis state is updated in the same edge that loads the result, so pin/position outputs
// are the axis registers themselves. Asynchronous active-low reset clears all axis state
// to zero (motors disabled) and returns the configuration registers to their defaults.
module two_axis_stepper_position_control_unit #(
	parameter int AXES = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tspc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tspc_pkg::LIMIT_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 func,
	input  logic                                 phase,
	input  logic                                 axis,
	input  logic signed [tspc_pkg::TARGET_W-1:0] target,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 x_step,
	output logic                                 x_dir,
	output logic                                 x_enable_n,
	output logic                                 y_step,
	output logic                                 y_dir,
	output logic                                 y_enable_n,
	output logic signed [tspc_pkg::POS_W-1:0]    x_position,
	output logic signed [tspc_pkg::POS_W-1:0]    y_position,
	output logic signed [tspc_pkg::METRIC_W-1:0] x_metric,
	output logic signed [tspc_pkg::METRIC_W-1:0] y_metric,
	output logic                                 target_accepted,
	output logic [tspc_pkg::POS_W-1:0]           remaining_distance
);
	import tspc_pkg::*;

	localparam int AW     = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int CONV_W = TARGET_W + SCALE_W + 1;
	localparam int T_W    = CONV_W - SCALE_SHIFT;

	// configuration
	logic [LIMIT_W-1:0] travel_limit_q;
	logic               metric_input_q;
	logic [SCALE_W-1:0] n2m_scale_q;
	logic [SCALE_W-1:0] m2n_scale_q;

	// request register
	logic                       valid_s1;
	logic                       func_s1;
	logic                       phase_s1;
	logic                       axis_s1;
	logic signed [TARGET_W-1:0] target_s1;

	// result register
	logic               out_valid_q;
	logic               accepted_q;
	logic [POS_W-1:0]   remaining_q;

	logic                    advance;
	logic                    is_set;
	logic                    present;
	logic [AW-1:0]           sel_idx;
	logic signed [CONV_W-1:0] conv_prod;
	logic signed [T_W-1:0]   t_conv;
	logic [T_W-1:0]          t_mag;
	logic                    in_limit;
	logic                    load_ok;
	logic signed [POS_W-1:0] tgt_new;
	logic signed [POS_W:0]   diff;
	logic [POS_W:0]          diff_mag;

	axis_cmd_t   cmd [AXES];
	axis_state_t st  [AXES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_limit_q <= LIMIT_RESET;
			metric_input_q <= 1'b0;
			n2m_scale_q    <= SCALE_RESET;
			m2n_scale_q    <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_TRAVEL_LIMIT: travel_limit_q <= cfg_data;
				CFG_METRIC_INPUT: metric_input_q <= cfg_data[0];
				CFG_N2M_SCALE:    n2m_scale_q    <= cfg_data;
				CFG_M2N_SCALE:    m2n_scale_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// the request stage empties whenever the result slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1   <= func;
			phase_s1  <= phase;
			axis_s1   <= axis;
			target_s1 <= target;
		end
	end

	// set-target conversion and limit check
	assign is_set    = func_s1;
	assign present   = 32'(axis_s1) < AXES;
	assign sel_idx   = AW'(axis_s1);
	assign conv_prod = target_s1 * $signed({1'b0, m2n_scale_q});
	assign t_conv    = metric_input_q ? conv_prod[CONV_W-1:SCALE_SHIFT]
	                                  : T_W'(target_s1);
	assign t_mag     = t_conv[T_W-1] ? T_W'(-t_conv) : t_conv;
	assign in_limit  = t_mag <= T_W'(travel_limit_q);
	assign load_ok   = is_set && present && in_limit;

	assign tgt_new  = in_limit ? t_conv[POS_W-1:0] : st[sel_idx].target;
	assign diff     = {tgt_new[POS_W-1], tgt_new} -
	                  {st[sel_idx].position[POS_W-1], st[sel_idx].position};
	assign diff_mag = diff[POS_W] ? (POS_W+1)'(-diff) : diff;

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		assign cmd[a].load   = advance && load_ok && (sel_idx == AW'(a));
		assign cmd[a].step   = advance && !func_s1 && phase_s1;
		assign cmd[a].drop   = advance && !func_s1 && !phase_s1;
		assign cmd[a].target = t_conv[POS_W-1:0];

		tspc_axis u_axis (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd[a]),
			.travel_limit (travel_limit_q),
			.scale        (n2m_scale_q),
			.state        (st[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accepted_q  <= load_ok;
			remaining_q <= (is_set && present) ? diff_mag[POS_W-1:0] : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign target_accepted    = accepted_q;
	assign remaining_distance = remaining_q;

	assign x_step     = st[0].step;
	assign x_dir      = st[0].dir;
	assign x_enable_n = !st[0].enable;
	assign x_position = st[0].position;
	assign x_metric   = st[0].metric;

	if (AXES > 1) begin : g_y
		assign y_step     = st[1].step;
		assign y_dir      = st[1].dir;
		assign y_enable_n = !st[1].enable;
		assign y_position = st[1].position;
		assign y_metric   = st[1].metric;
	end else begin : g_no_y
		assign y_step     = 1'b0;
		assign y_dir      = 1'b0;
		assign y_enable_n = 1'b1;
		assign y_position = '0;
		assign y_metric   = '0;
	end

`ifndef SYNTH
	// a stalled request stage only ever waits on a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("request stage stalled without a held result");

	// axis state must not move while its result is still held
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(x_position) && $stable(y_position)
			&& $stable(x_enable_n) && $stable(y_enable_n)))
		else $error("axis state changed under a held result");

	// a taken target enables some motor
	a_accept_enables: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && target_accepted) |-> !(x_enable_n && y_enable_n))
		else $error("accepted target left both motors disabled");

	// x position moves at most one step per request
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (x_position == $past(x_position)
			|| x_position == $past(x_position) + 16'sd1
			|| x_position == $past(x_position) - 16'sd1))
		else $error("x position jumped by more than one step");
`endif

endmodule
